// File: sv/lrut_pkg.sv
`timescale 1ns / 1ps
// lrut_pkg: shared types and constants for the lru cache table
// no dependencies; used by the interfaces, the lookup block and the top level

package lrut_pkg;

  localparam int KEY_W         = 32;
  localparam int DATA_W        = 32;
  localparam int CAP_W         = 5;
  localparam int ENTRIES_DEF   = 16;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    CMD_PUT = 1'b0,
    CMD_GET = 1'b1
  } cmd_t;

  // status from the lookup block to the update logic
  typedef struct packed {
    logic hit;
    logic evict;
  } lkup_stat_t;

endpackage

// File: sv/lrut_in_if.sv
`timescale 1ns / 1ps
// lrut_in_if: request channel (valid/ready plus command word)
// depends on lrut_pkg

interface lrut_in_if import lrut_pkg::*; ();
  logic                    valid;
  logic                    ready;
  cmd_t                    cmd;
  logic signed [KEY_W-1:0] key;
  logic [DATA_W-1:0]       value;

  modport source (output valid, cmd, key, value, input ready);
  modport sink   (input valid, cmd, key, value, output ready);
endinterface

// File: sv/lrut_out_if.sv
`timescale 1ns / 1ps
// lrut_out_if: result channel (valid/ready plus result word)
// depends on lrut_pkg

interface lrut_out_if import lrut_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic [DATA_W-1:0]       read_value;
  logic                    evicted;
  logic signed [KEY_W-1:0] evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

// File: sv/lrut_lookup.sv
`timescale 1ns / 1ps
// lrut_lookup: parallel key match, lru pick and free slot pick
// depends on lrut_pkg

module lrut_lookup import lrut_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
  input  cmd_t                                  cmd,
  input  logic signed [KEY_W-1:0]               key,
  input  logic [ENTRIES-1:0]                    valid_vec,
  input  logic [ENTRIES-1:0][KEY_W-1:0]         keys,
  input  logic [ENTRIES-1:0][RANK_W-1:0]        ranks,
  input  logic [CNT_W-1:0]                      count,
  input  logic [CAP_W-1:0]                      cap,
  output logic [ENTRIES-1:0]                    match_oh,
  output logic [ENTRIES-1:0]                    lru_oh,
  output logic [ENTRIES-1:0]                    slot_oh,
  output lkup_stat_t                            stat
);

  localparam int CW = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CW-1:0]      cap_ext;
  logic [CW-1:0]      cnt_ext;
  logic [CW-1:0]      eff_cap;
  logic [RANK_W-1:0]  oldest_rank;
  logic [ENTRIES-1:0] free_vec;

  assign cap_ext = CW'(cap);
  assign cnt_ext = CW'(count);

  // zero acts as one, anything above the table size acts as the table size
  always_comb begin
    if (cap == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // valid ranks are distinct 0..count-1, so the oldest holds count-1
  assign oldest_rank = RANK_W'(count - CNT_W'(1));

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_oh[i] = valid_vec[i] && (keys[i] == key);
      lru_oh[i]   = valid_vec[i] && (ranks[i] == oldest_rank);
    end
  end

  assign stat.hit   = |match_oh;
  assign stat.evict = (cmd == CMD_PUT) && !stat.hit && (cnt_ext >= eff_cap) && (count != '0);

  // first free slot, counting the one an eviction opens
  assign free_vec = ~valid_vec | (stat.evict ? lru_oh : '0);
  assign slot_oh  = free_vec & (~free_vec + ENTRIES'(1));

endmodule

// File: sv/lru_cache_table_unit.sv
`timescale 1ns / 1ps
// lru_cache_table_unit: fully associative key/value table with lru replacement
// depends on lrut_pkg, lrut_in_if, lrut_out_if, lrut_lookup

// Usage: each request word is a put (insert or update) or a get with a signed
// key. Every request yields exactly one result word in the cycle after it is
// accepted, and a new request can be accepted every cycle: the lookup, the
// recency update and the insert all complete in the cycle of acceptance, with
// the result held in an output register. in_ch.ready drops only while that
// output register is full and the consumer is not taking it. Keys and recency
// ranks live in flip-flops per entry and are compared in parallel; the single
// capacity register (cfg_we / cfg_wdata) limits how many entries fill before
// eviction starts and should be written while no request is in flight. There
// is no clearing pass: valid bits reset immediately.

module lru_cache_table_unit import lrut_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  lrut_in_if.sink          in_ch,
  lrut_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);

  // table state
  logic [CAP_W-1:0]                    cap_r;
  logic [ENTRIES-1:0]                  valid_r, valid_nxt;
  logic [ENTRIES-1:0][KEY_W-1:0]       keys_r, keys_nxt;
  logic [ENTRIES-1:0][VALUE_BITS-1:0]  vals_r, vals_nxt;
  logic [ENTRIES-1:0][RANK_W-1:0]      ranks_r, ranks_nxt;
  logic [CNT_W-1:0]                    cnt_r, cnt_nxt;

  // output register
  logic                    out_valid_r;
  logic                    hit_r, hit_nxt;
  logic [DATA_W-1:0]       rd_val_r, rd_val_nxt;
  logic                    evicted_r, evicted_nxt;
  logic signed [KEY_W-1:0] ev_key_r, ev_key_nxt;

  logic                    accept;
  logic                    in_ready;
  logic [ENTRIES-1:0]      match_oh, lru_oh, slot_oh;
  lkup_stat_t              stat;
  logic [VALUE_BITS-1:0]   wr_val;
  logic [VALUE_BITS-1:0]   hit_val;
  logic [KEY_W-1:0]        lru_key;
  logic [RANK_W-1:0]       hit_rank;
  logic                    is_get;

  // the output register frees up in the same cycle it is drained
  assign in_ready    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;
  assign is_get      = (in_ch.cmd == CMD_GET);
  assign wr_val      = VALUE_BITS'(in_ch.value);

  lrut_lookup #(
    .ENTRIES (ENTRIES),
    .RANK_W  (RANK_W),
    .CNT_W   (CNT_W)
  ) u_lookup (
    .cmd       (in_ch.cmd),
    .key       (in_ch.key),
    .valid_vec (valid_r),
    .keys      (keys_r),
    .ranks     (ranks_r),
    .count     (cnt_r),
    .cap       (cap_r),
    .match_oh  (match_oh),
    .lru_oh    (lru_oh),
    .slot_oh   (slot_oh),
    .stat      (stat)
  );

  // one-hot and-or selects: at most one entry matches, one is oldest
  always_comb begin
    hit_val  = '0;
    lru_key  = '0;
    hit_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_val  = hit_val  | (match_oh[i] ? vals_r[i]  : '0);
      hit_rank = hit_rank | (match_oh[i] ? ranks_r[i] : '0);
      lru_key  = lru_key  | (lru_oh[i]   ? keys_r[i]  : '0);
    end
  end

  // table update for the request being accepted
  always_comb begin
    valid_nxt = valid_r;
    keys_nxt  = keys_r;
    vals_nxt  = vals_r;
    ranks_nxt = ranks_r;
    cnt_nxt   = cnt_r;
    if (stat.hit) begin
      // hit: entry becomes newest, newer ones age by one
      for (int i = 0; i < ENTRIES; i++) begin
        if (match_oh[i]) begin
          ranks_nxt[i] = '0;
          if (!is_get) begin
            vals_nxt[i] = wr_val;
          end
        end else if (valid_r[i] && (ranks_r[i] < hit_rank)) begin
          ranks_nxt[i] = ranks_r[i] + RANK_W'(1);
        end
      end
    end else if (!is_get) begin
      // put miss: optional eviction, insert as newest, everyone else ages
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_oh[i]) begin
          valid_nxt[i] = 1'b1;
          keys_nxt[i]  = in_ch.key;
          vals_nxt[i]  = wr_val;
          ranks_nxt[i] = '0;
        end else if (stat.evict && lru_oh[i]) begin
          valid_nxt[i] = 1'b0;
          ranks_nxt[i] = '0;
        end else if (valid_r[i]) begin
          ranks_nxt[i] = ranks_r[i] + RANK_W'(1);
        end
      end
      if (!stat.evict) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  // result word
  always_comb begin
    hit_nxt     = stat.hit;
    rd_val_nxt  = (stat.hit && is_get) ? DATA_W'(hit_val) : '0;
    evicted_nxt = stat.evict;
    ev_key_nxt  = stat.evict ? lru_key : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      valid_r <= '0;
      ranks_r <= '0;
      cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (accept) begin
        valid_r <= valid_nxt;
        ranks_r <= ranks_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  // key and value storage, no reset: only read behind a valid bit
  always_ff @(posedge clk) begin
    if (accept) begin
      keys_r <= keys_nxt;
      vals_r <= vals_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r     <= hit_nxt;
      rd_val_r  <= rd_val_nxt;
      evicted_r <= evicted_nxt;
      ev_key_r  <= ev_key_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = hit_r;
  assign out_ch.read_value  = rd_val_r;
  assign out_ch.evicted     = evicted_r;
  assign out_ch.evicted_key = ev_key_r;

  // fill count tracks the valid bits
  a_cnt_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(cnt_r))
    else $error("entry count out of step with valid bits");

  // keys are unique among valid entries
  a_match_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_oh))
    else $error("key matches more than one entry");

  // an eviction always leaves a slot for the insert
  a_slot_on_put_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_get && !stat.hit) |-> $onehot(slot_oh))
    else $error("put miss found no free slot");

  // hit and eviction never appear together
  a_hit_xor_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(hit_r && evicted_r))
    else $error("result reports hit and eviction together");

  // every accepted request leaves a result in the output register
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted request produced no result");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for lru_cache_table_unit, with a directed table then random traffic
// depends on lrut_pkg, lrut_in_if, lrut_out_if and the lru_cache_table_unit rtl

module testbench;
  import lrut_pkg::*;

  localparam int      SLOTS       = ENTRIES_DEF;
  localparam int      POOL_SIZE   = 32;
  localparam int      PHASES      = 11;
  localparam int      PHASE_ITEMS = 178;
  localparam int      RUSH_ITEMS  = 30;
  localparam int      STALL_LIMIT = 1000;
  localparam logic [CAP_W-1:0] CAP_PLAN [10] = '{
    5'd16, 5'd1, 5'd0, 5'd4, 5'd31, 5'd8, 5'd2, 5'd16, 5'd17, 5'd12
  };

  typedef struct packed {
    logic                    hit;
    logic [DATA_W-1:0]       read_value;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;
  } result_t;

  typedef enum bit {
    ROW_WORD,
    ROW_CAP
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    cmd_t              cmd;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;   // capacity in the low bits on a ROW_CAP row
    bit                pinned;  // want is typed in and replaces the prediction
    result_t           want;
  } step_t;

  localparam result_t ALL_ZERO = '0;

  // directed part: walks from an empty table through hits, misses, updates,
  // a capacity lowered below the fill level, capacity zero and capacity 31
  step_t directed_plan [22] = '{
    '{ROW_WORD, CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, ALL_ZERO},
    '{ROW_WORD, CMD_PUT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, ALL_ZERO},
    '{ROW_WORD, CMD_PUT, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, ALL_ZERO},
    '{ROW_WORD, CMD_GET, 32'h8000_0000, 32'h0000_0000, 1'b1,
      '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
    '{ROW_WORD, CMD_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{1'b1, 32'h0, 1'b0, 32'h0}},
    '{ROW_WORD, CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1,
      '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
    '{ROW_WORD, CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ALL_ZERO},
    '{ROW_WORD, CMD_PUT, 32'h0000_0000, 32'h5A5A_5A5A, 1'b1, ALL_ZERO},
    '{ROW_WORD, CMD_PUT, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b1, ALL_ZERO},
    '{ROW_WORD, CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{1'b1, 32'h5A5A_5A5A, 1'b0, 32'h0}},
    // four entries held, capacity drops to two: each put miss evicts one
    '{ROW_CAP,  CMD_PUT, 32'h0, 32'd2, 1'b0, ALL_ZERO},
    '{ROW_WORD, CMD_PUT, 32'h0000_0001, 32'h0000_0001, 1'b1,
      '{1'b0, 32'h0, 1'b1, 32'h8000_0000}},
    '{ROW_WORD, CMD_PUT, 32'h0000_0002, 32'h0000_0002, 1'b1,
      '{1'b0, 32'h0, 1'b1, 32'h7FFF_FFFF}},
    // capacity zero behaves as one
    '{ROW_CAP,  CMD_PUT, 32'h0, 32'd0, 1'b0, ALL_ZERO},
    '{ROW_WORD, CMD_PUT, 32'h0000_0003, 32'h0000_0003, 1'b1,
      '{1'b0, 32'h0, 1'b1, 32'hFFFF_FFFF}},
    '{ROW_WORD, CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{1'b1, 32'h5A5A_5A5A, 1'b0, 32'h0}},
    '{ROW_WORD, CMD_PUT, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{1'b1, 32'h0, 1'b0, 32'h0}},
    // capacity above the table size behaves as the table size
    '{ROW_CAP,  CMD_PUT, 32'h0, 32'd31, 1'b0, ALL_ZERO},
    '{ROW_WORD, CMD_PUT, 32'h0000_0004, 32'h0000_002C, 1'b1, ALL_ZERO},
    '{ROW_WORD, CMD_GET, 32'h0000_0001, 32'h0000_0000, 1'b1,
      '{1'b1, 32'h0000_0001, 1'b0, 32'h0}},
    '{ROW_WORD, CMD_GET, 32'h0000_0002, 32'h0000_0000, 1'b0, ALL_ZERO},
    '{ROW_WORD, CMD_PUT, 32'h1234_5678, 32'hCAFE_F00D, 1'b0, ALL_ZERO}
  };

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  lrut_in_if  in_ch ();
  lrut_out_if out_ch ();

  lru_cache_table_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // shadow copy of the table kept by the predictor
  logic             shadow_valid [SLOTS];
  logic [KEY_W-1:0] shadow_key   [SLOTS];
  logic [DATA_W-1:0] shadow_value [SLOTS];
  int               shadow_rank  [SLOTS];
  int               shadow_count;
  logic [CAP_W-1:0] shadow_capacity;

  result_t          pending_results [$];
  bit               pin_next;
  result_t          pin_result;
  bit               rush;
  int               mismatches;
  int               idle_cycles;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  result_t          got_word;
  result_t          want_word;

  logic in_fire;
  logic out_fire;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // works out the result of one request and updates the shadow table
  function automatic result_t lru_lookup_update(input cmd_t cmd, input logic [KEY_W-1:0] key,
                                                input logic [DATA_W-1:0] value);
    result_t r;
    int      found;
    int      victim;
    int      slot;
    int      limit;
    int      old_rank;
    r      = '0;
    found  = -1;
    victim = -1;
    slot   = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (found < 0 && shadow_valid[i] && shadow_key[i] == key) found = i;
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      if (cmd == CMD_GET) r.read_value = shadow_value[found];
      else                shadow_value[found] = value;
      // promote to most recent: everything newer ages by one
      old_rank = shadow_rank[found];
      for (int i = 0; i < SLOTS; i++) begin
        if (shadow_valid[i] && shadow_rank[i] < old_rank) shadow_rank[i]++;
      end
      shadow_rank[found] = 0;
      return r;
    end
    if (cmd == CMD_GET) return r;

    limit = (shadow_capacity == 0) ? 1 : ((shadow_capacity > SLOTS) ? SLOTS : shadow_capacity);
    if (shadow_count >= limit && shadow_count > 0) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > shadow_rank[victim])) victim = i;
      end
      r.evicted         = 1'b1;
      r.evicted_key     = shadow_key[victim];
      shadow_valid[victim] = 1'b0;
      shadow_rank[victim]  = 0;
      shadow_count--;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (slot < 0 && !shadow_valid[i]) slot = i;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_valid[i]) shadow_rank[i]++;
    end
    shadow_valid[slot] = 1'b1;
    shadow_key[slot]   = key;
    shadow_value[slot] = value;
    shadow_rank[slot]  = 0;
    shadow_count++;
    return r;
  endfunction

  // predictor and scoreboard, all on the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        shadow_valid[i] = 1'b0;
        shadow_rank[i]  = 0;
      end
      shadow_count    = 0;
      shadow_capacity = CAP_RESET;
      pending_results.delete();
    end else begin
      if (cfg_we) shadow_capacity = cfg_wdata;
      if (in_fire) begin
        want_word = lru_lookup_update(in_ch.cmd, in_ch.key, in_ch.value);
        // typed-in rows override the prediction, the shadow table still advances
        if (pin_next) want_word = pin_result;
        pending_results.push_back(want_word);
      end
      if (out_fire) begin
        got_word = '{out_ch.hit, out_ch.read_value, out_ch.evicted, out_ch.evicted_key};
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected");
          mismatches++;
        end else begin
          want_word = pending_results.pop_front();
          if (got_word.hit !== want_word.hit) begin
            $error("hit: expected %0d, got %0d", want_word.hit, got_word.hit);
            mismatches++;
          end
          if (got_word.read_value !== want_word.read_value) begin
            $error("read_value: expected %h, got %h", want_word.read_value, got_word.read_value);
            mismatches++;
          end
          if (got_word.evicted !== want_word.evicted) begin
            $error("evicted: expected %0d, got %0d", want_word.evicted, got_word.evicted);
            mismatches++;
          end
          if (got_word.evicted_key !== want_word.evicted_key) begin
            $error("evicted_key: expected %h, got %h", want_word.evicted_key,
                   got_word.evicted_key);
            mismatches++;
          end
        end
      end
    end
  end

  // watchdog: too long without any word or register write moving
  always @(posedge clk) begin
    if (in_fire || out_fire || cfg_we) idle_cycles <= 0;
    else                               idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: random stall before taking each word, none while rushing
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = rush ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  // offers one request word after a random gap, returns at the falling edge after it is taken
  task automatic send_word(input cmd_t cmd, input logic [KEY_W-1:0] key,
                           input logic [DATA_W-1:0] value, input bit pinned,
                           input result_t want);
    int gap;
    gap = rush ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= cmd;
    in_ch.key   <= key;
    in_ch.value <= value;
    pin_next     = pinned;
    pin_result   = want;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // hold off requests until every outstanding result has been taken
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [CAP_W-1:0] cap;
    int               limit;
    int               span;
    cmd_t             cmd;
    logic [KEY_W-1:0] key;

    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd   = CMD_PUT;
    in_ch.key   = '0;
    in_ch.value = '0;
    pin_next    = 1'b0;
    pin_result  = '0;
    rush        = 1'b0;
    mismatches  = 0;
    idle_cycles = 0;

    // keys reused often enough to hit, with the extremes always in the pool
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CAP)
        set_capacity(directed_plan[i].value[CAP_W-1:0]);
      else
        send_word(directed_plan[i].cmd, directed_plan[i].key, directed_plan[i].value,
                  directed_plan[i].pinned, directed_plan[i].want);
    end

    // random phases, one capacity setting each, the last one drawn at random
    for (int p = 0; p < PHASES; p++) begin
      cap = (p < $size(CAP_PLAN)) ? CAP_PLAN[p] : CAP_W'($urandom_range(0, 31));
      set_capacity(cap);
      limit = (cap == 0) ? 1 : ((cap > SLOTS) ? SLOTS : cap);
      span  = limit + $urandom_range(1, 8);
      if (span > POOL_SIZE) span = POOL_SIZE;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        rush = (n < RUSH_ITEMS);
        // mid-phase pause with the table still populated
        if (n == PHASE_ITEMS / 2) wait_drained();
        cmd = cmd_t'($urandom_range(0, 1));
        key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, span - 1)] : $urandom;
        send_word(cmd, key, $urandom, 1'b0, ALL_ZERO);
      end
    end
    rush = 1'b0;

    wait_drained();
    repeat (5) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
